>>> design/edrk_pkg.sv
// ----------------------------------------------------------------------------
// edrk_pkg
// Shared types and constants for the descriptor ring keeper.
// ----------------------------------------------------------------------------
package edrk_pkg;

  localparam int unsigned RING_DEPTH = 256;

  localparam int unsigned IDX_W    = 16;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STATUS_W = 3;

  localparam logic [15:0] FLAG_SOP        = 16'h2000;
  localparam logic [15:0] FLAG_EOP        = 16'h4000;
  localparam logic [15:0] FLAG_RX_ERR     = 16'h001f;
  localparam logic [15:0] FLAG_APPEND_CRC = 16'h0040;
  localparam logic [15:0] QTAG_ALL        = 16'h003f;

  localparam logic [LEN_W-1:0] RX_MIN_LEN  = LEN_W'(16);
  localparam logic [LEN_W-1:0] RX_BUF_LEN  = LEN_W'(2048);
  localparam logic [LEN_W-1:0] RX_ALIGN    = LEN_W'(2);
  localparam logic [LEN_W-1:0] RX_CRC_LEN  = LEN_W'(4);
  localparam logic [15:0]      TX_MAX_LEN  = 16'(1536 - 4);
  localparam logic [15:0]      TX_MIN_LEN  = 16'(60);
  localparam logic [IDX_W-1:0] RING_LIMIT  = IDX_W'(RING_DEPTH - 1);
  localparam logic [IDX_W-1:0] SLOT_MASK   = IDX_W'(RING_DEPTH - 1);

  localparam logic [15:0] TX_DESC_FLAGS =
    (QTAG_ALL << 7) | FLAG_SOP | FLAG_EOP | FLAG_APPEND_CRC;

  typedef enum logic [STATUS_W-1:0] {
    ST_RX_OK     = 3'd0,
    ST_RX_ERR    = 3'd1,
    ST_RX_EMPTY  = 3'd2,
    ST_TX_QUEUED = 3'd3,
    ST_LINK_DOWN = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_RING_FULL = 3'd6
  } status_t;

  typedef enum logic {
    FUNC_RX = 1'b0,
    FUNC_TX = 1'b1
  } func_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] desc_status;
    logic [IDX_W-1:0]  rx_producer;
    logic [15:0]       tx_length;
    logic [IDX_W-1:0]  tx_consumer;
    logic              link_up;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  frame_length;
    logic [WORD_W-1:0] desc_word;
    logic [IDX_W-1:0]  ring_index;
    logic [CNT_W-1:0]  error_total;
  } result_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] m;
    m = idx & SLOT_MASK;
    return m[SLOT_W-1:0];
  endfunction

endpackage

>>> design/ethernet_descriptor_ring_keeper_unit.sv
// ----------------------------------------------------------------------------
// ethernet_descriptor_ring_keeper_unit
// Receive descriptor check and transmit admission for one descriptor ring.
// ----------------------------------------------------------------------------
// Each transaction is registered in the input register and again in the result register.
// Throughput: 1 transaction per cycle while out_stall stays low, set by the
// single evaluation stage between the input register and the result register.
// Reset: synchronous, active low; indices, error count and crc_forward clear.
// ----------------------------------------------------------------------------
module ethernet_descriptor_ring_keeper_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [31:0] in_desc_status,
  input  logic [15:0] in_rx_producer,
  input  logic [15:0] in_tx_length,
  input  logic [15:0] in_tx_consumer,
  input  logic        in_link_up,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_slot,
  output logic [11:0] out_frame_length,
  output logic [31:0] out_desc_word,
  output logic [15:0] out_ring_index,
  output logic [31:0] out_error_total
);
  import edrk_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    fire;
  logic    res_ready;
  result_t res;
  result_t out_res;

  assign in_item.func        = in_func;
  assign in_item.desc_status = in_desc_status;
  assign in_item.rx_producer = in_rx_producer;
  assign in_item.tx_length   = in_tx_length;
  assign in_item.tx_consumer = in_tx_consumer;
  assign in_item.link_up     = in_link_up;

  edrk_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  edrk_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .fire       (fire),
    .res        (res)
  );

  edrk_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status       = out_res.status;
  assign out_slot         = out_res.slot;
  assign out_frame_length = out_res.frame_length;
  assign out_desc_word    = out_res.desc_word;
  assign out_ring_index   = out_res.ring_index;
  assign out_error_total  = out_res.error_total;

endmodule

>>> design/edrk_in_stage.sv
// ----------------------------------------------------------------------------
// edrk_in_stage
// Input register: captures one transaction and holds it until the core takes it.
// ----------------------------------------------------------------------------
module edrk_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  edrk_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output edrk_pkg::item_t item
);
  import edrk_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign load      = !valid_r || take;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> design/edrk_core.sv
// ----------------------------------------------------------------------------
// edrk_core
// Ring index and error count state with the receive check and transmit
// admission logic.
// ----------------------------------------------------------------------------
module edrk_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             item_valid,
  input  edrk_pkg::item_t  item,
  input  logic             res_ready,
  output logic             fire,
  output edrk_pkg::result_t res
);
  import edrk_pkg::*;

  logic [IDX_W-1:0] rx_cons_r, rx_cons_nxt;
  logic [IDX_W-1:0] tx_prod_r, tx_prod_nxt;
  logic [CNT_W-1:0] err_cnt_r, err_cnt_nxt;
  logic             crc_fwd_r;

  logic [LEN_W-1:0] rx_len;
  logic [15:0]      rx_flags;
  logic             rx_empty;
  logic             rx_bad;
  logic [LEN_W-1:0] rx_deliver;
  logic [IDX_W-1:0] tx_used;
  logic [15:0]      tx_pad;
  logic             is_tx;

  assign fire  = item_valid && res_ready;
  assign is_tx = (item.func == FUNC_TX);

  assign rx_len   = item.desc_status[27:16];
  assign rx_flags = item.desc_status[15:0];
  assign rx_empty = (rx_cons_r == item.rx_producer);
  assign rx_bad   = ((rx_flags & (FLAG_SOP | FLAG_EOP)) != (FLAG_SOP | FLAG_EOP)) ||
                    ((rx_flags & FLAG_RX_ERR) != 16'h0000) ||
                    (rx_len < RX_MIN_LEN) || (rx_len > RX_BUF_LEN);
  assign rx_deliver = crc_fwd_r ? (rx_len - RX_ALIGN - RX_CRC_LEN) : (rx_len - RX_ALIGN);

  assign tx_used = tx_prod_r - item.tx_consumer;
  assign tx_pad  = (item.tx_length < TX_MIN_LEN) ? TX_MIN_LEN : item.tx_length;

  always_comb begin
    rx_cons_nxt      = rx_cons_r;
    tx_prod_nxt      = tx_prod_r;
    err_cnt_nxt      = err_cnt_r;
    res.frame_length = '0;
    res.desc_word    = '0;
    if (!is_tx) begin
      res.slot = slot_of(rx_cons_r);
      if (rx_empty) begin
        res.status = ST_RX_EMPTY;
      end else begin
        rx_cons_nxt = rx_cons_r + IDX_W'(1);
        if (rx_bad) begin
          err_cnt_nxt = err_cnt_r + CNT_W'(1);
          res.status  = ST_RX_ERR;
        end else begin
          res.frame_length = rx_deliver;
          res.status       = ST_RX_OK;
        end
      end
      res.ring_index = rx_cons_nxt;
    end else begin
      res.slot = slot_of(tx_prod_r);
      if (!item.link_up) begin
        res.status = ST_LINK_DOWN;
      end else if (item.tx_length > TX_MAX_LEN) begin
        res.status = ST_TOO_LONG;
      end else if (tx_used >= RING_LIMIT) begin
        res.status = ST_RING_FULL;
      end else begin
        res.status       = ST_TX_QUEUED;
        res.frame_length = tx_pad[LEN_W-1:0];
        res.desc_word    = {4'h0, tx_pad[LEN_W-1:0], TX_DESC_FLAGS};
        tx_prod_nxt      = tx_prod_r + IDX_W'(1);
      end
      res.ring_index = tx_prod_nxt;
    end
    res.error_total = err_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_cons_r <= '0;
      tx_prod_r <= '0;
      err_cnt_r <= '0;
      crc_fwd_r <= 1'b0;
    end else begin
      if (fire) begin
        rx_cons_r <= rx_cons_nxt;
        tx_prod_r <= tx_prod_nxt;
        err_cnt_r <= err_cnt_nxt;
      end
      if (cfg_we) begin
        crc_fwd_r <= cfg_wdata;
      end
    end
  end

  a_rx_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !is_tx && !rx_empty |=> rx_cons_r == $past(rx_cons_r) + IDX_W'(1))
    else $error("receive consumer index did not advance");

  a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && res.status == ST_TX_QUEUED) |=> $stable(tx_prod_r))
    else $error("transmit producer index moved without a queued frame");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && res.status == ST_RX_ERR) |=> $stable(err_cnt_r))
    else $error("error count moved without a bad descriptor");

  a_tx_pad: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.status == ST_TX_QUEUED |-> res.frame_length >= TX_MIN_LEN[LEN_W-1:0])
    else $error("queued frame shorter than minimum");

endmodule

>>> design/edrk_out_stage.sv
// ----------------------------------------------------------------------------
// edrk_out_stage
// Result register: holds one result transaction while the receiver stalls.
// ----------------------------------------------------------------------------
module edrk_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  edrk_pkg::result_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output edrk_pkg::result_t out_res
);
  import edrk_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign res_ready = !valid_r || !out_stall;
  assign valid_nxt = res_ready ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
